// ===== hdl/htc_pkg.sv =====
// Shared types, widths and constants for the humidity and temperature compensation block.
`default_nettype none

package htc_pkg;

  // Port field widths
  localparam int RAW_TEMP_W  = 20;
  localparam int RAW_HUM_W   = 16;
  localparam int TEMP_W      = 16;
  localparam int HUM_W       = 17;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Internal widths
  localparam int FINE_W = 24;
  localparam int V_W    = 25;

  // Pipeline depth: temperature part, then humidity part
  localparam int NSTAGE      = 14;
  localparam int TEMP_STAGES = 4;
  localparam int HUM_STAGES  = NSTAGE - TEMP_STAGES;

  // Arithmetic constants
  localparam logic signed [V_W-1:0] FINE_OFFSET    = 25'sd76800;
  localparam logic signed [27:0]    TEMP_ROUND     = 28'sd128;
  localparam logic signed [38:0]    HUM_ROUND      = 39'sd16384;
  localparam logic signed [23:0]    B2_OFFSET      = 24'sd32768;
  localparam logic signed [37:0]    B_OFFSET       = 38'sd2097152;
  localparam logic signed [54:0]    B_ROUND        = 55'sd8192;
  localparam logic        [28:0]    HUM_FULL_SCALE = 29'd419430400;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN    = 16'sh8000;

  // Calibration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TEMP_CAL_1   = 3'd0,
    CFG_TEMP_CAL_2   = 3'd1,
    CFG_TEMP_CAL_3   = 3'd2,
    CFG_HUM_CAL_1    = 3'd3,
    CFG_HUM_CAL_2    = 3'd4,
    CFG_HUM_CAL_3    = 3'd5,
    CFG_HUM_CAL_4_5  = 3'd6,
    CFG_HUM_CAL_6    = 3'd7
  } cfg_index_t;

  // Calibration set as seen by the datapath
  typedef struct packed {
    logic [15:0] temp_cal_1;
    logic [15:0] temp_cal_2;
    logic [15:0] temp_cal_3;
    logic [7:0]  hum_cal_1;
    logic [15:0] hum_cal_2;
    logic [7:0]  hum_cal_3;
    logic [23:0] hum_cal_4_5;
    logic [7:0]  hum_cal_6;
  } cal_t;

endpackage

`default_nettype wire

// ===== hdl/htc_cfg.sv =====
// Calibration register file written through the configuration channel.
`default_nettype none

module htc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [htc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [htc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output htc_pkg::cal_t                        cal
);

  htc_pkg::cal_t cal_reg;

  // Register writes, one word per accepted write
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_reg <= '0;
    end else if (cfg_valid) begin
      unique case (htc_pkg::cfg_index_t'(cfg_index))
        htc_pkg::CFG_TEMP_CAL_1:  cal_reg.temp_cal_1  <= cfg_data[15:0];
        htc_pkg::CFG_TEMP_CAL_2:  cal_reg.temp_cal_2  <= cfg_data[15:0];
        htc_pkg::CFG_TEMP_CAL_3:  cal_reg.temp_cal_3  <= cfg_data[15:0];
        htc_pkg::CFG_HUM_CAL_1:   cal_reg.hum_cal_1   <= cfg_data[7:0];
        htc_pkg::CFG_HUM_CAL_2:   cal_reg.hum_cal_2   <= cfg_data[15:0];
        htc_pkg::CFG_HUM_CAL_3:   cal_reg.hum_cal_3   <= cfg_data[7:0];
        htc_pkg::CFG_HUM_CAL_4_5: cal_reg.hum_cal_4_5 <= cfg_data[23:0];
        htc_pkg::CFG_HUM_CAL_6:   cal_reg.hum_cal_6   <= cfg_data[7:0];
      endcase
    end
  end

  assign cal = cal_reg;

endmodule

`default_nettype wire

// ===== hdl/htc_ctrl.sv =====
// Valid bits and stage enables of the elastic pipeline.
`default_nettype none

module htc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       out_ready,
  output logic [htc_pkg::NSTAGE-1:0]      en,
  output logic                            out_valid
);

  logic [htc_pkg::NSTAGE-1:0] valid;

  // A stage loads when it is empty or its word moves on
  assign en[htc_pkg::NSTAGE-1] = !valid[htc_pkg::NSTAGE-1] || out_ready;

  for (genvar i = 0; i < htc_pkg::NSTAGE - 1; i++) begin : g_en
    assign en[i] = !valid[i] || en[i+1];
  end

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < htc_pkg::NSTAGE; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign out_valid = valid[htc_pkg::NSTAGE-1];

endmodule

`default_nettype wire

// ===== hdl/htc_temp.sv =====
// Temperature stages: fine temperature, saturated temperature and humidity offset term.
`default_nettype none

module htc_temp (
  input  wire logic                               clk,
  input  wire logic [htc_pkg::TEMP_STAGES-1:0]    en,
  input  wire logic [htc_pkg::RAW_TEMP_W-1:0]     raw_temp,
  input  wire logic [htc_pkg::RAW_HUM_W-1:0]      raw_hum,
  input  wire htc_pkg::cal_t                      cal,
  output logic signed [htc_pkg::TEMP_W-1:0]       temp_centi,
  output logic signed [htc_pkg::V_W-1:0]          v,
  output logic [htc_pkg::RAW_HUM_W-1:0]           raw_hum_out
);

  // Stage 0: first-order product and squared offset
  logic signed [17:0] diff1;
  logic signed [16:0] d;
  logic signed [33:0] m1_next;
  logic signed [33:0] dd_next;
  logic signed [33:0] s0_m1;
  logic        [31:0] s0_dd;
  logic [htc_pkg::RAW_HUM_W-1:0] s0_hum;

  assign diff1   = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, cal.temp_cal_1, 1'b0});
  assign d       = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, cal.temp_cal_1});
  assign m1_next = diff1 * $signed(cal.temp_cal_2);
  assign dd_next = d * d;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_m1  <= m1_next;
      s0_dd  <= dd_next[31:0];
      s0_hum <= raw_hum;
    end
  end

  // Stage 1: scale first term, second-order product
  logic signed [35:0] m2_next;
  logic signed [22:0] s1_p1;
  logic signed [35:0] s1_m2;
  logic [htc_pkg::RAW_HUM_W-1:0] s1_hum;

  assign m2_next = $signed({1'b0, s0_dd[31:12]}) * $signed(cal.temp_cal_3);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_p1  <= s0_m1[33:11];
      s1_m2  <= m2_next;
      s1_hum <= s0_hum;
    end
  end

  // Stage 2: fine temperature
  logic signed [htc_pkg::FINE_W-1:0] fine_next;
  logic signed [htc_pkg::FINE_W-1:0] s2_fine;
  logic [htc_pkg::RAW_HUM_W-1:0] s2_hum;

  assign fine_next = $signed({s1_p1[22], s1_p1}) + $signed({{2{s1_m2[35]}}, s1_m2[35:14]});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_fine <= fine_next;
      s2_hum  <= s1_hum;
    end
  end

  // Stage 3: temperature in hundredths with saturation, humidity offset
  logic signed [27:0] fine_x;
  logic signed [27:0] t_sum;
  logic signed [19:0] t_hi;
  logic signed [htc_pkg::TEMP_W-1:0] temp_next;
  logic signed [htc_pkg::V_W-1:0]    v_next;

  assign fine_x = $signed({{4{s2_fine[23]}}, s2_fine});
  assign t_sum  = (fine_x <<< 2) + fine_x + htc_pkg::TEMP_ROUND;
  assign t_hi   = t_sum[27:8];
  assign v_next = $signed({s2_fine[23], s2_fine}) - htc_pkg::FINE_OFFSET;

  always_comb begin
    if (t_hi[19:15] == 5'b00000 || t_hi[19:15] == 5'b11111) begin
      temp_next = t_hi[15:0];
    end else if (t_hi[19]) begin
      temp_next = htc_pkg::TEMP_MIN;
    end else begin
      temp_next = htc_pkg::TEMP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      temp_centi  <= temp_next;
      v           <= v_next;
      raw_hum_out <= s2_hum;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/htc_hum.sv =====
// Humidity stages: product chain, quadratic correction and clamping.
`default_nettype none

module htc_hum (
  input  wire logic                               clk,
  input  wire logic [htc_pkg::HUM_STAGES-1:0]     en,
  input  wire logic signed [htc_pkg::TEMP_W-1:0]  temp_in,
  input  wire logic signed [htc_pkg::V_W-1:0]     v,
  input  wire logic [htc_pkg::RAW_HUM_W-1:0]      raw_hum,
  input  wire htc_pkg::cal_t                      cal,
  output logic signed [htc_pkg::TEMP_W-1:0]       temp_centi,
  output logic [htc_pkg::HUM_W-1:0]               hum_q10
);

  // Temperature rides along beside the humidity work
  logic signed [htc_pkg::TEMP_W-1:0] temp_d [htc_pkg::HUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      temp_d[0] <= temp_in;
    end
    for (int i = 1; i < htc_pkg::HUM_STAGES - 1; i++) begin
      if (en[i]) begin
        temp_d[i] <= temp_d[i-1];
      end
    end
    if (en[htc_pkg::HUM_STAGES-1]) begin
      temp_centi <= temp_d[htc_pkg::HUM_STAGES-2];
    end
  end

  // Stage 0: products of the offset term with words five, six and three
  logic signed [36:0] hv_next;
  logic signed [32:0] m6_next;
  logic signed [33:0] m3_next;
  logic signed [36:0] s0_hv;
  logic signed [32:0] s0_m6;
  logic signed [33:0] s0_m3;
  logic [htc_pkg::RAW_HUM_W-1:0] s0_hum;

  assign hv_next = $signed(cal.hum_cal_4_5[23:12]) * v;
  assign m6_next = v * $signed(cal.hum_cal_6);
  assign m3_next = v * $signed({1'b0, cal.hum_cal_3});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_hv  <= hv_next;
      s0_m6  <= m6_next;
      s0_m3  <= m3_next;
      s0_hum <= raw_hum;
    end
  end

  // Stage 1: first factor and the two halves of the second
  logic signed [38:0] a_sum;
  logic signed [23:0] b2_next;
  logic signed [23:0] s1_a;
  logic signed [22:0] s1_b1;
  logic signed [23:0] s1_b2;

  assign a_sum = $signed({9'b0, s0_hum, 14'b0})
               - $signed({{7{cal.hum_cal_4_5[11]}}, cal.hum_cal_4_5[11:0], 20'b0})
               - $signed({{2{s0_hv[36]}}, s0_hv})
               + htc_pkg::HUM_ROUND;
  assign b2_next = $signed({s0_m3[33], s0_m3[33:11]}) + htc_pkg::B2_OFFSET;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a  <= a_sum[38:15];
      s1_b1 <= s0_m6[32:10];
      s1_b2 <= b2_next;
    end
  end

  // Stage 2: inner product
  logic signed [46:0] bb_next;
  logic signed [46:0] s2_bb;
  logic signed [23:0] s2_a;

  assign bb_next = s1_b1 * s1_b2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_bb <= bb_next;
      s2_a  <= s1_a;
    end
  end

  // Stage 3: offset and scale by word two
  logic signed [37:0] c_sum;
  logic signed [53:0] m_next;
  logic signed [53:0] s3_m;
  logic signed [23:0] s3_a;

  assign c_sum  = $signed({s2_bb[46], s2_bb[46:10]}) + htc_pkg::B_OFFSET;
  assign m_next = c_sum * $signed(cal.hum_cal_2);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_m <= m_next;
      s3_a <= s2_a;
    end
  end

  // Stage 4: round the second factor
  logic signed [54:0] b_sum;
  logic signed [40:0] s4_b;
  logic signed [23:0] s4_a;

  assign b_sum = $signed({s3_m[53], s3_m}) + htc_pkg::B_ROUND;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_b <= b_sum[54:14];
      s4_a <= s3_a;
    end
  end

  // Stage 5: wide product split into two partial products
  logic signed [44:0] plo_next;
  logic signed [44:0] phi_next;
  logic signed [44:0] s5_plo;
  logic signed [44:0] s5_phi;

  assign plo_next = s4_a * $signed({1'b0, s4_b[19:0]});
  assign phi_next = s4_a * $signed(s4_b[40:20]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_plo <= plo_next;
      s5_phi <= phi_next;
    end
  end

  // Stage 6: combine, classify sign and magnitude
  logic signed [66:0] v_sum;
  logic               s6_neg;
  logic               s6_big;
  logic        [42:0] s6_vlo;

  assign v_sum = $signed({{22{s5_plo[44]}}, s5_plo})
               + $signed({{2{s5_phi[44]}}, s5_phi, 20'b0});

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_neg <= v_sum[66];
      s6_big <= |v_sum[65:43];
      s6_vlo <= v_sum[42:0];
    end
  end

  // Stage 7: square of the scaled value
  logic [55:0] qq_next;
  logic [55:0] s7_qq;
  logic        s7_neg;
  logic        s7_big;
  logic [42:0] s7_vlo;

  assign qq_next = s6_vlo[42:15] * s6_vlo[42:15];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_qq  <= qq_next;
      s7_neg <= s6_neg;
      s7_big <= s6_big;
      s7_vlo <= s6_vlo;
    end
  end

  // Stage 8: quadratic correction scaled by byte one
  logic [56:0] corr_prod;
  logic [52:0] s8_corr;
  logic        s8_neg;
  logic        s8_big;
  logic [42:0] s8_vlo;

  assign corr_prod = s7_qq[55:7] * cal.hum_cal_1;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_corr <= corr_prod[56:4];
      s8_neg  <= s7_neg;
      s8_big  <= s7_big;
      s8_vlo  <= s7_vlo;
    end
  end

  // Stage 9: subtract and clamp to 0..100 percent
  logic signed [53:0] diff;
  logic        [28:0] r_next;

  assign diff = $signed({11'b0, s8_vlo}) - $signed({1'b0, s8_corr});

  always_comb begin
    if (s8_neg) begin
      r_next = '0;
    end else if (s8_big) begin
      // too large to correct: byte one of zero keeps it, otherwise it collapses
      r_next = (cal.hum_cal_1 == 8'd0) ? htc_pkg::HUM_FULL_SCALE : '0;
    end else if (diff[53]) begin
      r_next = '0;
    end else if (diff[52:0] > {24'b0, htc_pkg::HUM_FULL_SCALE}) begin
      r_next = htc_pkg::HUM_FULL_SCALE;
    end else begin
      r_next = diff[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      hum_q10 <= r_next[28:12];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/humidity_temperature_compensation_top.sv =====
// Top level of the humidity and temperature compensation block.
//
// Takes one word per cycle of raw temperature and raw humidity readings and returns
// temperature in hundredths of a degree (saturated to 16 bits signed) and relative
// humidity in percent times 1024 (0..102400), using the integer compensation scheme
// with calibration words held in eight registers written through the cfg channel.
// Each word passes through every pipeline stage; the depth is set by the chain of
// multiplications, each followed by its own register. The pipeline is elastic: one
// word can be accepted every cycle, and back-pressure on the output stalls every
// stage without loss. Calibration registers should be written only while the block
// holds no words.
`default_nettype none

module humidity_temperature_compensation_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave side
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [htc_pkg::S_TDATA_W-1:0]   s_tdata,   // raw_temp[19:0], raw_hum[35:20]
  // master side
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [htc_pkg::M_TDATA_W-1:0]        m_tdata,   // temp_centi[15:0], hum_q10[32:16]
  // calibration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [htc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [htc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  htc_pkg::cal_t cal;
  logic [htc_pkg::NSTAGE-1:0]             en;
  logic signed [htc_pkg::TEMP_W-1:0]      temp_mid;
  logic signed [htc_pkg::V_W-1:0]         v_mid;
  logic [htc_pkg::RAW_HUM_W-1:0]          hum_mid;
  logic signed [htc_pkg::TEMP_W-1:0]      temp_centi;
  logic [htc_pkg::HUM_W-1:0]              hum_q10;

  // Calibration registers, always writable
  assign cfg_ready = 1'b1;

  htc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  // Pipeline control
  htc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .en        (en),
    .out_valid (m_tvalid)
  );

  assign s_tready = en[0];

  // Temperature stages
  htc_temp u_temp (
    .clk         (clk),
    .en          (en[htc_pkg::TEMP_STAGES-1:0]),
    .raw_temp    (s_tdata[19:0]),
    .raw_hum     (s_tdata[35:20]),
    .cal         (cal),
    .temp_centi  (temp_mid),
    .v           (v_mid),
    .raw_hum_out (hum_mid)
  );

  // Humidity stages
  htc_hum u_hum (
    .clk        (clk),
    .en         (en[htc_pkg::NSTAGE-1:htc_pkg::TEMP_STAGES]),
    .temp_in    (temp_mid),
    .v          (v_mid),
    .raw_hum    (hum_mid),
    .cal        (cal),
    .temp_centi (temp_centi),
    .hum_q10    (hum_q10)
  );

  // Output word
  assign m_tdata = {7'b0, hum_q10, temp_centi};

endmodule

`default_nettype wire

// ===== hdl/htc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level.
`default_nettype none

module htc_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tready,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [htc_pkg::M_TDATA_W-1:0]   m_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // A held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // Humidity never exceeds full scale
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[32:16] <= 17'd102400)
    else $error("humidity above full scale");

  // Padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:33] == 7'd0)
    else $error("output padding not zero");

  // With no word at the output nothing upstream can stall the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind humidity_temperature_compensation_top htc_checker u_htc_checker (.*);

`default_nettype wire
